/* rtl/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants for the separator-set field splitter
// Holds register indexes, field widths, reset values and the token limit clamp.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 12;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MAP_W    = 256;

    // Limits
    localparam logic [COUNT_W-1:0] TOKEN_LIMIT_MAX = 7'd64;
    localparam logic [COUNT_W-1:0] TOKEN_LIMIT_MIN = 7'd1;
    localparam logic [POS_W-1:0]   POS_MAX         = 12'd4095;

    // Line terminators
    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;

    // Register reset values: tab and space are separators
    localparam logic [CFG_DATA_W-1:0] SEP_MAP_0_RESET = 64'h0000_0001_0000_0200;
    localparam logic [COUNT_W-1:0]    MAX_TOKENS_RESET = 7'd16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEP_MAP_0  = 3'd0,
        REG_SEP_MAP_1  = 3'd1,
        REG_SEP_MAP_2  = 3'd2,
        REG_SEP_MAP_3  = 3'd3,
        REG_MAX_TOKENS = 3'd4
    } cfg_reg_e;

    // Settings handed from the register file to the splitter core
    typedef struct packed {
        logic [MAP_W-1:0]   sep_map;
        logic [COUNT_W-1:0] token_limit;
    } cfg_t;

    // Clamp a written token limit into 1..64
    function automatic logic [COUNT_W-1:0] clamp_limit(input logic [COUNT_W-1:0] raw);
        logic [COUNT_W-1:0] lim;
        begin
            lim = raw;
            if (lim < TOKEN_LIMIT_MIN)
            begin
                lim = TOKEN_LIMIT_MIN;
            end
            if (lim > TOKEN_LIMIT_MAX)
            begin
                lim = TOKEN_LIMIT_MAX;
            end
            return lim;
        end
    endfunction

endpackage

/* rtl/sfs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sfs_cfg_regs: configuration register file
// Holds the 256-bit separator map and the clamped token limit.
// ----------------------------------------------------------------------------
module sfs_cfg_regs
    import sfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [CFG_DATA_W-1:0] map0_reg;
    logic [CFG_DATA_W-1:0] map1_reg;
    logic [CFG_DATA_W-1:0] map2_reg;
    logic [CFG_DATA_W-1:0] map3_reg;
    logic [COUNT_W-1:0]    limit_reg;
    logic                  cfg_write;

    // Always take a write
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Decode the index and store the word; drop writes past the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map0_reg  <= SEP_MAP_0_RESET;
            map1_reg  <= '0;
            map2_reg  <= '0;
            map3_reg  <= '0;
            limit_reg <= MAX_TOKENS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SEP_MAP_0:  map0_reg  <= cfg_data;
                REG_SEP_MAP_1:  map1_reg  <= cfg_data;
                REG_SEP_MAP_2:  map2_reg  <= cfg_data;
                REG_SEP_MAP_3:  map3_reg  <= cfg_data;
                REG_MAX_TOKENS: limit_reg <= clamp_limit(cfg_data[COUNT_W-1:0]);
                default:        ;
            endcase
        end
    end

    assign cfg.sep_map     = {map3_reg, map2_reg, map1_reg, map0_reg};
    assign cfg.token_limit = limit_reg;

endmodule

/* rtl/sfs_core.sv */
// ----------------------------------------------------------------------------
// sfs_core: splitter datapath
// Input register, byte classification and phase update, result register.
// ----------------------------------------------------------------------------
module sfs_core
    import sfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  in_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [POS_W-1:0]   position,
    output logic               token_start,
    output logic [IDX_W-1:0]   token_index,
    output logic               line_end,
    output logic [COUNT_W-1:0] token_count
);

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_SEP   = 2'd2,
        PH_PASS  = 2'd3
    } phase_t;

    // Line state
    phase_t             phase_reg,  phase_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [COUNT_W-1:0] seen_reg,   seen_next;

    // Input stage
    logic               s1_valid_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;

    // Result stage
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg,   out_byte_next;
    logic [POS_W-1:0]   position_reg;
    logic               start_reg,      start_next;
    logic [IDX_W-1:0]   index_reg,      index_next;
    logic               line_end_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               out_free;
    logic               s1_move;
    logic               is_term;
    logic               is_sep;
    logic [COUNT_W-1:0] seen_inc;

    // Handshake: the result register frees when empty or taken
    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // Classify the held byte
    assign is_term  = (s1_byte_reg == CHAR_NUL) || (s1_byte_reg == CHAR_LF);
    assign is_sep   = !is_term && cfg.sep_map[s1_byte_reg];
    assign seen_inc = seen_reg + COUNT_W'(1);

    // Work out the result and the next line state
    always_comb
    begin
        phase_next    = phase_reg;
        seen_next     = seen_reg;
        out_byte_next = s1_byte_reg;
        start_next    = 1'b0;
        index_next    = '0;

        if (is_term)
        begin
            if (phase_reg == PH_SKIP)
            begin
                start_next = 1'b1;
                seen_next  = TOKEN_LIMIT_MIN;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (!is_sep)
                    begin
                        start_next = 1'b1;
                        seen_next  = TOKEN_LIMIT_MIN;
                        phase_next = (TOKEN_LIMIT_MIN >= cfg.token_limit) ? PH_PASS
                                                                          : PH_TOKEN;
                    end
                end
                PH_TOKEN:
                begin
                    if (is_sep)
                    begin
                        if (seen_reg < cfg.token_limit)
                        begin
                            out_byte_next = '0;
                            phase_next    = PH_SEP;
                        end
                        else
                        begin
                            phase_next = PH_PASS;
                        end
                    end
                end
                PH_SEP:
                begin
                    if (!is_sep)
                    begin
                        start_next = 1'b1;
                        index_next = seen_reg[IDX_W-1:0];
                        seen_next  = seen_inc;
                        phase_next = (seen_inc >= cfg.token_limit) ? PH_PASS : PH_TOKEN;
                    end
                end
                PH_PASS:
                begin
                end
                default:
                begin
                end
            endcase
        end

        // Advance the position, saturating; restart after a terminator
        if (is_term)
        begin
            pos_next = '0;
        end
        else if (pos_reg < POS_MAX)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // Hold state, the input word and the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            pos_reg       <= '0;
            seen_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_byte_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            position_reg  <= '0;
            start_reg     <= 1'b0;
            index_reg     <= '0;
            line_end_reg  <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
                if (in_valid)
                begin
                    s1_byte_reg <= in_byte;
                end
            end

            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end

            if (s1_move)
            begin
                out_byte_reg <= out_byte_next;
                position_reg <= pos_reg;
                start_reg    <= start_next;
                index_reg    <= index_next;
                line_end_reg <= is_term;
                count_reg    <= seen_next;

                if (is_term)
                begin
                    phase_reg <= PH_SKIP;
                    seen_reg  <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    seen_reg  <= seen_next;
                end
                pos_reg <= pos_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign position    = position_reg;
    assign token_start = start_reg;
    assign token_index = index_reg;
    assign line_end    = line_end_reg;
    assign token_count = count_reg;

endmodule

/* rtl/separator_set_field_splitter.sv */
// ----------------------------------------------------------------------------
// separator_set_field_splitter: in-place line tokeniser on a separator set
// Top level joining the configuration registers and the splitter core.
// ----------------------------------------------------------------------------
// One byte word is taken per cycle when the output is not stalled, and one result
// word leaves per byte, passing through the input register and then the result
// register. The separator map lookup and the phase update sit between these two
// registers, so a full byte rate is kept for any run of bytes; while a result
// waits at the output the input register takes one more word and then holds the
// input until the result is taken.
// Configuration writes complete in the cycle they are presented and should be
// made only while no byte is in flight.
// ----------------------------------------------------------------------------
module separator_set_field_splitter
    import sfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     in_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     out_byte,
    output logic [POS_W-1:0]      position,
    output logic                  token_start,
    output logic [IDX_W-1:0]      token_index,
    output logic                  line_end,
    output logic [COUNT_W-1:0]    token_count
);

    cfg_t cfg;

    sfs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .position    (position),
        .token_start (token_start),
        .token_index (token_index),
        .line_end    (line_end),
        .token_count (token_count)
    );

endmodule

/* rtl/sfs_checker.sv */
// ----------------------------------------------------------------------------
// sfs_checker: port-level checks for the field splitter
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module sfs_checker
    import sfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [BYTE_W-1:0]     out_byte,
    input  logic [POS_W-1:0]      position,
    input  logic                  token_start,
    input  logic [IDX_W-1:0]      token_index,
    input  logic                  line_end,
    input  logic [COUNT_W-1:0]    token_count
);

    logic after_end_reg;

    // Track whether the next result word opens a new line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_end_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            after_end_reg <= line_end;
        end
    end

    // A token start always brings the count to its index plus one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_start |-> token_count == ({1'b0, token_index} + COUNT_W'(1)))
        else $error("token count does not follow the starting token index");

    // A terminator passes unchanged and closes a line with at least one token
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |->
            (out_byte == CHAR_NUL || out_byte == CHAR_LF) && token_count != '0)
        else $error("line end word is malformed");

    // The first word of a line sits at position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && after_end_reg |-> position == '0)
        else $error("new line does not start at position zero");

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(position))
        else $error("result word changed while stalled");

endmodule

bind separator_set_field_splitter sfs_checker u_sfs_checker (.*);
